// ===== rtl/core/pti_pkg.sv =====
package pti_pkg;

   localparam int COORD_W = 32;
   localparam int TIME_W = 48;
   localparam int LEVEL_W = 16;
   // Signed difference of two timestamps.
   localparam int DIFF_W = TIME_W + 1;

   // The multiplier takes a coordinate times one chunk of a 50-bit time operand.
   localparam int CHUNK_W = 25;
   localparam int OPND_W = 2 * CHUNK_W;
   localparam int PROD_W = COORD_W + CHUNK_W + 1;
   localparam int ACC_W = PROD_W + CHUNK_W;
   localparam int MAG_W = ACC_W - 1;

   localparam int MUL_STEPS = 4;
   localparam int DIV_STEPS = COORD_W;
   localparam int STEP_W = 5;

   localparam logic [COORD_W-1:0] SAT_POS = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] SAT_NEG = {1'b1, {(COORD_W-1){1'b0}}};

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_CHECK,
      S_CALC,
      S_EMIT
   } top_state_type;

   typedef enum logic [2:0] {
      L_IDLE,
      L_MUL,
      L_ABS,
      L_CMP,
      L_DIV,
      L_SAT,
      L_DONE
   } lane_state_type;

   typedef struct packed {
      logic                     start;
      logic signed [DIFF_W-1:0] elapsed;
      logic signed [DIFF_W-1:0] gap;
   } lane_cmd_type;

endpackage

// ===== rtl/core/position_time_interpolator.sv =====
// Position time interpolator: smooths a stream of position fixes in time.
// The request channel (req_) carries one fix and the time at which a position is
// wanted; a transfer happens on a clock edge with req_valid high and req_stall low.
// The response channel (rsp_) returns exactly one position for every request.
// The block holds the two latest fixes and blends x and y linearly between them.
// Items are processed one at a time. A request that returns a stored or incoming
// fix unchanged passes through S_DECIDE, S_CHECK and S_EMIT into the output
// register, and the next request can transfer once the block is back in S_IDLE.
// A blended request also passes through S_CALC, where two x/y lanes each run a
// 32x25 multiply-accumulate forming the numerator and then a one-bit-per-cycle
// restoring divide; that divide is the longest part of a blended item.
// The response sits in an output register, so the next request is taken while a
// finished response still waits; when rsp_stall holds, the following result waits
// inside the block and req_stall stays high until the output register frees up.
// A synchronous reset empties both fix slots (level 0, marked empty) and drops any
// pending response.
module position_time_interpolator (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [pti_pkg::COORD_W-1:0]   req_fix_x,
   input  logic signed [pti_pkg::COORD_W-1:0]   req_fix_y,
   input  logic [pti_pkg::TIME_W-1:0]           req_fix_time,
   input  logic [pti_pkg::LEVEL_W-1:0]          req_fix_level,
   input  logic                                 req_fix_empty,
   input  logic [pti_pkg::TIME_W-1:0]           req_now_time,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [pti_pkg::COORD_W-1:0]   rsp_out_x,
   output logic signed [pti_pkg::COORD_W-1:0]   rsp_out_y,
   output logic [pti_pkg::TIME_W-1:0]           rsp_out_time,
   output logic [pti_pkg::LEVEL_W-1:0]          rsp_out_level,
   output logic                                 rsp_out_empty
);

   pti_pkg::top_state_type state_ff, state_in;

   // Captured request.
   logic signed [pti_pkg::COORD_W-1:0] in_x_ff, in_y_ff;
   logic [pti_pkg::TIME_W-1:0]         in_time_ff, in_now_ff;
   logic [pti_pkg::LEVEL_W-1:0]        in_level_ff;
   logic                               in_empty_ff;

   // Fix slots.
   logic signed [pti_pkg::COORD_W-1:0] old_x_ff, old_x_in, old_y_ff, old_y_in;
   logic [pti_pkg::TIME_W-1:0]         old_time_ff, old_time_in;
   logic [pti_pkg::LEVEL_W-1:0]        old_level_ff, old_level_in;
   logic                               old_empty_ff, old_empty_in;
   logic signed [pti_pkg::COORD_W-1:0] new_x_ff, new_x_in, new_y_ff, new_y_in;
   logic [pti_pkg::TIME_W-1:0]         new_time_ff, new_time_in;
   logic [pti_pkg::LEVEL_W-1:0]        new_level_ff, new_level_in;
   logic                               new_empty_ff, new_empty_in;

   logic                               skip_ff, skip_in;
   logic signed [pti_pkg::DIFF_W-1:0]  elap_ff, elap_in;
   logic signed [pti_pkg::DIFF_W-1:0]  gap_ff, gap_in;

   // Pending result.
   logic signed [pti_pkg::COORD_W-1:0] res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic [pti_pkg::TIME_W-1:0]         res_time_ff, res_time_in;
   logic [pti_pkg::LEVEL_W-1:0]        res_level_ff, res_level_in;
   logic                               res_empty_ff, res_empty_in;
   logic                               blend_ff, blend_in;

   // Output register.
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [pti_pkg::COORD_W-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [pti_pkg::TIME_W-1:0]         out_time_ff, out_time_in;
   logic [pti_pkg::LEVEL_W-1:0]        out_level_ff, out_level_in;
   logic                               out_empty_ff, out_empty_in;

   logic accept;
   logic before_fix, level_chg, any_empty, newer_fix;
   logic same_time, extrap, go_blend;
   logic out_free, load_out, lane_start;
   logic signed [pti_pkg::DIFF_W-1:0] elap_keep, gap_keep, elap_shift, gap_shift;

   pti_pkg::lane_cmd_type              lane_cmd;
   logic                               lane_x_done, lane_y_done;
   logic signed [pti_pkg::COORD_W-1:0] lane_x_res, lane_y_res;

   assign accept = req_valid && !req_stall;

   assign before_fix = in_now_ff < in_time_ff;
   assign level_chg  = (old_level_ff != in_level_ff) || (new_level_ff != in_level_ff);
   assign any_empty  = old_empty_ff || new_empty_ff || in_empty_ff;
   assign newer_fix  = in_time_ff > new_time_ff;

   // Both candidate differences are formed in parallel and chosen afterward.
   assign elap_keep  = {1'b0, in_now_ff} - {1'b0, new_time_ff};
   assign gap_keep   = {1'b0, new_time_ff} - {1'b0, old_time_ff};
   assign elap_shift = {1'b0, in_now_ff} - {1'b0, in_time_ff};
   assign gap_shift  = {1'b0, in_time_ff} - {1'b0, new_time_ff};

   assign same_time = new_time_ff == old_time_ff;
   assign extrap    = elap_ff > gap_ff;
   assign go_blend  = !skip_ff && !same_time && !extrap;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pti_pkg::S_IDLE: begin
            if (accept) begin
               state_in = pti_pkg::S_DECIDE;
            end
         end
         pti_pkg::S_DECIDE: state_in = pti_pkg::S_CHECK;
         pti_pkg::S_CHECK: begin
            state_in = go_blend ? pti_pkg::S_CALC : pti_pkg::S_EMIT;
         end
         pti_pkg::S_CALC: begin
            if (lane_x_done) begin
               state_in = pti_pkg::S_EMIT;
            end
         end
         pti_pkg::S_EMIT: begin
            if (out_free) begin
               state_in = pti_pkg::S_IDLE;
            end
         end
         default: state_in = pti_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_stall  = (state_ff != pti_pkg::S_IDLE);
      lane_start = (state_ff == pti_pkg::S_CHECK) && go_blend;
      load_out   = (state_ff == pti_pkg::S_EMIT) && out_free;
   end

   assign lane_cmd.start   = lane_start;
   assign lane_cmd.elapsed = elap_ff;
   assign lane_cmd.gap     = gap_ff;

   pti_lane u_lane_x (
      .clock     (clock),
      .reset     (reset),
      .cmd       (lane_cmd),
      .new_coord (new_x_ff),
      .old_coord (old_x_ff),
      .done      (lane_x_done),
      .result    (lane_x_res)
   );

   pti_lane u_lane_y (
      .clock     (clock),
      .reset     (reset),
      .cmd       (lane_cmd),
      .new_coord (new_y_ff),
      .old_coord (old_y_ff),
      .done      (lane_y_done),
      .result    (lane_y_res)
   );

   // Slot update and difference selection.
   always_comb begin
      old_x_in     = old_x_ff;
      old_y_in     = old_y_ff;
      old_time_in  = old_time_ff;
      old_level_in = old_level_ff;
      old_empty_in = old_empty_ff;
      new_x_in     = new_x_ff;
      new_y_in     = new_y_ff;
      new_time_in  = new_time_ff;
      new_level_in = new_level_ff;
      new_empty_in = new_empty_ff;
      skip_in      = skip_ff;
      elap_in      = elap_ff;
      gap_in       = gap_ff;
      if (state_ff == pti_pkg::S_DECIDE) begin
         skip_in = before_fix || level_chg || any_empty;
         elap_in = newer_fix ? elap_shift : elap_keep;
         gap_in  = newer_fix ? gap_shift : gap_keep;
         if (!before_fix) begin
            if (level_chg) begin
               old_x_in     = in_x_ff;
               old_y_in     = in_y_ff;
               old_time_in  = in_time_ff;
               old_level_in = in_level_ff;
               old_empty_in = in_empty_ff;
               new_x_in     = in_x_ff;
               new_y_in     = in_y_ff;
               new_time_in  = in_time_ff;
               new_level_in = in_level_ff;
               new_empty_in = in_empty_ff;
            end else if (any_empty || newer_fix) begin
               old_x_in     = new_x_ff;
               old_y_in     = new_y_ff;
               old_time_in  = new_time_ff;
               old_level_in = new_level_ff;
               old_empty_in = new_empty_ff;
               new_x_in     = in_x_ff;
               new_y_in     = in_y_ff;
               new_time_in  = in_time_ff;
               new_level_in = in_level_ff;
               new_empty_in = in_empty_ff;
            end
         end
      end
   end

   // Result selection; a blended result takes x and y from the lanes later.
   always_comb begin
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      res_time_in  = res_time_ff;
      res_level_in = res_level_ff;
      res_empty_in = res_empty_ff;
      blend_in     = blend_ff;
      if (state_ff == pti_pkg::S_CHECK) begin
         res_x_in     = in_x_ff;
         res_y_in     = in_y_ff;
         res_time_in  = in_time_ff;
         res_level_in = in_level_ff;
         res_empty_in = in_empty_ff;
         blend_in     = go_blend;
         if (!skip_ff) begin
            if (same_time) begin
               res_x_in     = new_x_ff;
               res_y_in     = new_y_ff;
               res_time_in  = new_time_ff;
               res_level_in = new_level_ff;
               res_empty_in = new_empty_ff;
            end else if (!extrap) begin
               res_time_in  = in_now_ff;
               res_level_in = new_level_ff;
               res_empty_in = new_empty_ff;
            end
         end
      end
   end

   // Merge stage: lane results or the pass-through position into the output register.
   always_comb begin
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_time_in  = out_time_ff;
      out_level_in = out_level_ff;
      out_empty_in = out_empty_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load_out) begin
         out_x_in     = blend_ff ? lane_x_res : res_x_ff;
         out_y_in     = blend_ff ? lane_y_res : res_y_ff;
         out_time_in  = res_time_ff;
         out_level_in = res_level_ff;
         out_empty_in = res_empty_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pti_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         old_x_ff     <= '0;
         old_y_ff     <= '0;
         old_time_ff  <= '0;
         old_level_ff <= '0;
         old_empty_ff <= 1'b1;
         new_x_ff     <= '0;
         new_y_ff     <= '0;
         new_time_ff  <= '0;
         new_level_ff <= '0;
         new_empty_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         old_x_ff     <= old_x_in;
         old_y_ff     <= old_y_in;
         old_time_ff  <= old_time_in;
         old_level_ff <= old_level_in;
         old_empty_ff <= old_empty_in;
         new_x_ff     <= new_x_in;
         new_y_ff     <= new_y_in;
         new_time_ff  <= new_time_in;
         new_level_ff <= new_level_in;
         new_empty_ff <= new_empty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_x_ff     <= req_fix_x;
         in_y_ff     <= req_fix_y;
         in_time_ff  <= req_fix_time;
         in_level_ff <= req_fix_level;
         in_empty_ff <= req_fix_empty;
         in_now_ff   <= req_now_time;
      end
      skip_ff      <= skip_in;
      elap_ff      <= elap_in;
      gap_ff       <= gap_in;
      res_x_ff     <= res_x_in;
      res_y_ff     <= res_y_in;
      res_time_ff  <= res_time_in;
      res_level_ff <= res_level_in;
      res_empty_ff <= res_empty_in;
      blend_ff     <= blend_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_time_ff  <= out_time_in;
      out_level_ff <= out_level_in;
      out_empty_ff <= out_empty_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = out_x_ff;
   assign rsp_out_y     = out_y_ff;
   assign rsp_out_time  = out_time_ff;
   assign rsp_out_level = out_level_ff;
   assign rsp_out_empty = out_empty_ff;

   a_lane_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      lane_x_done |-> (state_ff == pti_pkg::S_CALC))
      else $error("lane finished outside the calculation phase");

   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      lane_x_done == lane_y_done)
      else $error("x and y lanes are out of step");

   a_blend_gap_nonzero: assert property (@(posedge clock) disable iff (reset)
      lane_start |-> (gap_ff != '0))
      else $error("blend started with a zero time gap");

   a_floor_change_loads_both: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pti_pkg::S_DECIDE && !before_fix && level_chg)
      |=> (new_level_ff == old_level_ff) && (new_time_ff == old_time_ff))
      else $error("floor change did not load both slots");

endmodule

// ===== rtl/core/pti_lane.sv =====
module pti_lane (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pti_pkg::lane_cmd_type                 cmd,
   input  logic signed [pti_pkg::COORD_W-1:0]    new_coord,
   input  logic signed [pti_pkg::COORD_W-1:0]    old_coord,
   output logic                                  done,
   output logic signed [pti_pkg::COORD_W-1:0]    result
);

   pti_pkg::lane_state_type state_ff, state_in;
   logic [pti_pkg::STEP_W-1:0] step_ff, step_in;

   logic signed [pti_pkg::COORD_W-1:0] new_ff, new_in;
   logic signed [pti_pkg::COORD_W-1:0] old_ff, old_in;
   logic signed [pti_pkg::OPND_W-1:0]  elap_ff, elap_in;
   logic signed [pti_pkg::OPND_W-1:0]  rest_ff, rest_in;
   logic [pti_pkg::TIME_W-1:0]         div_ff, div_in;
   logic                               gap_neg_ff, gap_neg_in;
   logic                               num_neg_ff, num_neg_in;
   logic                               sat_ff, sat_in;
   logic signed [pti_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic [pti_pkg::MAG_W-1:0]          mag_ff, mag_in;
   logic [pti_pkg::TIME_W-1:0]         rem_ff, rem_in;
   logic [pti_pkg::COORD_W-1:0]        quo_ff, quo_in;
   logic signed [pti_pkg::COORD_W-1:0] result_ff, result_in;

   logic signed [pti_pkg::COORD_W-1:0]   mul_a;
   logic signed [pti_pkg::OPND_W-1:0]    mul_b;
   logic signed [pti_pkg::CHUNK_W:0]     mul_c;
   logic signed [pti_pkg::PROD_W-1:0]    prod;
   logic signed [pti_pkg::ACC_W-1:0]     part;
   logic [pti_pkg::DIFF_W-1:0]           gap_abs;
   logic [pti_pkg::ACC_W-1:0]            acc_abs;
   logic [pti_pkg::TIME_W:0]             rem_sh;
   logic [pti_pkg::TIME_W:0]             rem_diff;
   logic                                 fits;
   logic                                 quo_neg;
   logic [pti_pkg::COORD_W-1:0]          quo_twos;

   // The numerator new*e + old*(g-e) is built from four signed partial products:
   // the low chunk of each time operand is unsigned, the high chunk signed.
   assign mul_a = step_ff[1] ? old_ff : new_ff;
   assign mul_b = step_ff[1] ? rest_ff : elap_ff;
   assign mul_c = step_ff[0] ?
                  {mul_b[pti_pkg::OPND_W-1], mul_b[pti_pkg::OPND_W-1:pti_pkg::CHUNK_W]} :
                  {1'b0, mul_b[pti_pkg::CHUNK_W-1:0]};
   assign prod = mul_a * mul_c;
   assign part = step_ff[0] ? {prod, {pti_pkg::CHUNK_W{1'b0}}} :
                              {{pti_pkg::CHUNK_W{prod[pti_pkg::PROD_W-1]}}, prod};

   assign gap_abs = cmd.gap[pti_pkg::DIFF_W-1] ? (~cmd.gap + pti_pkg::DIFF_W'(1)) : cmd.gap;
   assign acc_abs = acc_ff[pti_pkg::ACC_W-1] ? (~acc_ff + pti_pkg::ACC_W'(1)) : acc_ff;

   assign rem_sh   = {rem_ff, quo_ff[pti_pkg::COORD_W-1]};
   assign fits     = rem_sh >= {1'b0, div_ff};
   assign rem_diff = rem_sh - {1'b0, div_ff};

   assign quo_neg  = num_neg_ff ^ gap_neg_ff;
   assign quo_twos = ~quo_ff + pti_pkg::COORD_W'(1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pti_pkg::L_IDLE: begin
            if (cmd.start) begin
               state_in = pti_pkg::L_MUL;
            end
         end
         pti_pkg::L_MUL: begin
            if (step_ff == pti_pkg::STEP_W'(pti_pkg::MUL_STEPS - 1)) begin
               state_in = pti_pkg::L_ABS;
            end
         end
         pti_pkg::L_ABS:  state_in = pti_pkg::L_CMP;
         pti_pkg::L_CMP:  state_in = pti_pkg::L_DIV;
         pti_pkg::L_DIV: begin
            if (step_ff == pti_pkg::STEP_W'(pti_pkg::DIV_STEPS - 1)) begin
               state_in = pti_pkg::L_SAT;
            end
         end
         pti_pkg::L_SAT:  state_in = pti_pkg::L_DONE;
         pti_pkg::L_DONE: state_in = pti_pkg::L_IDLE;
         default:         state_in = pti_pkg::L_IDLE;
      endcase
   end

   always_comb begin
      done = (state_ff == pti_pkg::L_DONE);
   end

   always_comb begin
      step_in    = step_ff;
      new_in     = new_ff;
      old_in     = old_ff;
      elap_in    = elap_ff;
      rest_in    = rest_ff;
      div_in     = div_ff;
      gap_neg_in = gap_neg_ff;
      num_neg_in = num_neg_ff;
      sat_in     = sat_ff;
      acc_in     = acc_ff;
      mag_in     = mag_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      result_in  = result_ff;
      case (state_ff)
         pti_pkg::L_IDLE: begin
            if (cmd.start) begin
               step_in    = '0;
               new_in     = new_coord;
               old_in     = old_coord;
               elap_in    = {cmd.elapsed[pti_pkg::DIFF_W-1], cmd.elapsed};
               rest_in    = {cmd.gap[pti_pkg::DIFF_W-1], cmd.gap} -
                            {cmd.elapsed[pti_pkg::DIFF_W-1], cmd.elapsed};
               div_in     = gap_abs[pti_pkg::TIME_W-1:0];
               gap_neg_in = cmd.gap[pti_pkg::DIFF_W-1];
               acc_in     = '0;
            end
         end
         pti_pkg::L_MUL: begin
            acc_in  = acc_ff + part;
            step_in = step_ff + pti_pkg::STEP_W'(1);
         end
         pti_pkg::L_ABS: begin
            mag_in     = acc_abs[pti_pkg::MAG_W-1:0];
            num_neg_in = acc_ff[pti_pkg::ACC_W-1];
         end
         pti_pkg::L_CMP: begin
            // A quotient of 2^32 or more saturates, so only 32 quotient bits are developed.
            sat_in  = mag_ff[pti_pkg::MAG_W-1:pti_pkg::DIV_STEPS] >=
                      {{(pti_pkg::MAG_W-pti_pkg::DIV_STEPS-pti_pkg::TIME_W){1'b0}}, div_ff};
            rem_in  = mag_ff[pti_pkg::DIV_STEPS+pti_pkg::TIME_W-1:pti_pkg::DIV_STEPS];
            quo_in  = mag_ff[pti_pkg::DIV_STEPS-1:0];
            step_in = '0;
         end
         pti_pkg::L_DIV: begin
            rem_in  = fits ? rem_diff[pti_pkg::TIME_W-1:0] : rem_sh[pti_pkg::TIME_W-1:0];
            quo_in  = {quo_ff[pti_pkg::COORD_W-2:0], fits};
            step_in = step_ff + pti_pkg::STEP_W'(1);
         end
         pti_pkg::L_SAT: begin
            if (sat_ff) begin
               result_in = quo_neg ? pti_pkg::SAT_NEG : pti_pkg::SAT_POS;
            end else if (quo_neg) begin
               result_in = (quo_ff > pti_pkg::SAT_NEG) ? pti_pkg::SAT_NEG : quo_twos;
            end else begin
               result_in = (quo_ff > pti_pkg::SAT_POS) ? pti_pkg::SAT_POS : quo_ff;
            end
         end
         pti_pkg::L_DONE: begin
            step_in = step_ff;
         end
         default: begin
            step_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pti_pkg::L_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      new_ff     <= new_in;
      old_ff     <= old_in;
      elap_ff    <= elap_in;
      rest_ff    <= rest_in;
      div_ff     <= div_in;
      gap_neg_ff <= gap_neg_in;
      num_neg_ff <= num_neg_in;
      sat_ff     <= sat_in;
      acc_ff     <= acc_in;
      mag_ff     <= mag_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      result_ff  <= result_in;
   end

   assign result = result_ff;

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [pti_pkg::TIME_W-1:0] TIME_MAX = '1;
   localparam int DIRECTED_ROWS = 24;
   localparam int RANDOM_ITEMS = 1800;
   localparam int DRAIN_EVERY = 450;
   localparam int CYCLE_LIMIT = 1200000;

   typedef struct packed {
      logic signed [pti_pkg::COORD_W-1:0] x;
      logic signed [pti_pkg::COORD_W-1:0] y;
      logic [pti_pkg::TIME_W-1:0]         stamp;
      logic [pti_pkg::LEVEL_W-1:0]        level;
      logic                               empty;
   } fix_rec_type;

   typedef struct packed {
      fix_rec_type                fix;
      logic [pti_pkg::TIME_W-1:0] now;
   } req_item_type;

   typedef struct packed {
      req_item_type item;
      logic         typed;
      fix_rec_type  want;
   } request_row_type;

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_stall;
   logic signed [pti_pkg::COORD_W-1:0] req_fix_x;
   logic signed [pti_pkg::COORD_W-1:0] req_fix_y;
   logic [pti_pkg::TIME_W-1:0]         req_fix_time;
   logic [pti_pkg::LEVEL_W-1:0]        req_fix_level;
   logic                               req_fix_empty;
   logic [pti_pkg::TIME_W-1:0]         req_now_time;
   logic                               rsp_valid;
   logic                               rsp_stall;
   logic signed [pti_pkg::COORD_W-1:0] rsp_out_x;
   logic signed [pti_pkg::COORD_W-1:0] rsp_out_y;
   logic [pti_pkg::TIME_W-1:0]         rsp_out_time;
   logic [pti_pkg::LEVEL_W-1:0]        rsp_out_level;
   logic                               rsp_out_empty;

   fix_rec_type expected_positions[$];
   fix_rec_type prev_slot;
   fix_rec_type last_slot;
   int          mismatch_count = 0;
   int          requests_sent = 0;
   int          cycle_count = 0;
   logic        calm;

   // Expected values are typed in only where they follow directly from the rules.
   request_row_type directed_rows [DIRECTED_ROWS] = '{
      // Query before the fix while the slots are still empty.
      '{'{'{32'sd5, -32'sd7, 48'd100, 16'd0, 1'b0}, 48'd50}, 1'b1,
        '{32'sd5, -32'sd7, 48'd100, 16'd0, 1'b0}},
      '{'{'{32'sh7FFF_FFFF, 32'sh8000_0000, 48'd1000, 16'd0, 1'b0}, 48'd1000}, 1'b1,
        '{32'sh7FFF_FFFF, 32'sh8000_0000, 48'd1000, 16'd0, 1'b0}},
      '{'{'{-32'sd4096, 32'sd4096, 48'd2000, 16'd0, 1'b0}, 48'd2000}, 1'b1,
        '{-32'sd4096, 32'sd4096, 48'd2000, 16'd0, 1'b0}},
      '{'{'{-32'sd4096, 32'sd4096, 48'd2000, 16'd0, 1'b0}, 48'd2500}, 1'b0, '0},
      '{'{'{-32'sd4096, 32'sd4096, 48'd2000, 16'd0, 1'b0}, 48'd3000}, 1'b0, '0},
      // One past the stored gap: no extrapolation.
      '{'{'{-32'sd4096, 32'sd4096, 48'd2000, 16'd0, 1'b0}, 48'd3001}, 1'b1,
        '{-32'sd4096, 32'sd4096, 48'd2000, 16'd0, 1'b0}},
      '{'{'{32'sd123, 32'sd456, 48'd500, 16'd0, 1'b0}, 48'd1500}, 1'b0, '0},
      // Far backward extrapolation saturates both coordinates.
      '{'{'{32'sd0, 32'sd0, 48'd0, 16'd0, 1'b0}, 48'd0}, 1'b1,
        '{pti_pkg::SAT_POS, pti_pkg::SAT_NEG, 48'd0, 16'd0, 1'b0}},
      '{'{'{32'sd77, -32'sd77, 48'd2500, 16'd0, 1'b1}, 48'd2600}, 1'b1,
        '{32'sd77, -32'sd77, 48'd2500, 16'd0, 1'b1}},
      '{'{'{32'sh8000_0000, 32'sh7FFF_FFFF, TIME_MAX, 16'hFFFF, 1'b0}, TIME_MAX}, 1'b1,
        '{32'sh8000_0000, 32'sh7FFF_FFFF, TIME_MAX, 16'hFFFF, 1'b0}},
      '{'{'{32'sh8000_0000, 32'sh7FFF_FFFF, TIME_MAX, 16'hFFFF, 1'b0}, TIME_MAX}, 1'b1,
        '{32'sh8000_0000, 32'sh7FFF_FFFF, TIME_MAX, 16'hFFFF, 1'b0}},
      '{'{'{32'sd1, 32'sd2, TIME_MAX - 48'd1000, 16'hFFFF, 1'b0}, TIME_MAX}, 1'b1,
        '{32'sh8000_0000, 32'sh7FFF_FFFF, TIME_MAX, 16'hFFFF, 1'b0}},
      '{'{'{32'sd4096000, -32'sd4096000, TIME_MAX - 48'd2000, 16'h1234, 1'b0},
          TIME_MAX - 48'd2000}, 1'b1,
        '{32'sd4096000, -32'sd4096000, TIME_MAX - 48'd2000, 16'h1234, 1'b0}},
      '{'{'{32'sd8192000, 32'sd0, TIME_MAX - 48'd1000, 16'h1234, 1'b0}, TIME_MAX},
        1'b0, '0},
      '{'{'{32'sd8192000, 32'sd0, TIME_MAX - 48'd1000, 16'h1234, 1'b0},
          TIME_MAX - 48'd250}, 1'b0, '0},
      '{'{'{32'sd0, 32'sd0, TIME_MAX - 48'd5000, 16'h1234, 1'b0}, TIME_MAX - 48'd3000},
        1'b0, '0},
      '{'{'{32'sd12, 32'sd34, TIME_MAX - 48'd1000, 16'h1234, 1'b0},
          TIME_MAX - 48'd3000}, 1'b1,
        '{32'sd12, 32'sd34, TIME_MAX - 48'd1000, 16'h1234, 1'b0}},
      '{'{'{32'sd0, 32'sd0, 48'd10, 16'h00FF, 1'b1}, 48'd10}, 1'b1,
        '{32'sd0, 32'sd0, 48'd10, 16'h00FF, 1'b1}},
      '{'{'{32'sd4096, 32'sd8192, 48'd5000, 16'h00FF, 1'b0}, 48'd5000}, 1'b1,
        '{32'sd4096, 32'sd8192, 48'd5000, 16'h00FF, 1'b0}},
      // An older fix shifted in behind a newer one leaves a negative gap.
      '{'{'{-32'sd4096, -32'sd8192, 48'd3000, 16'h00FF, 1'b0}, 48'd3000}, 1'b1,
        '{-32'sd4096, -32'sd8192, 48'd3000, 16'h00FF, 1'b0}},
      '{'{'{32'sd5, 32'sd6, 48'd0, 16'h00FF, 1'b0}, 48'd1500}, 1'b1,
        '{32'sd5, 32'sd6, 48'd0, 16'h00FF, 1'b0}},
      '{'{'{32'sd5, 32'sd6, 48'd0, 16'h00FF, 1'b0}, 48'd1000}, 1'b0, '0},
      '{'{'{32'sd5, 32'sd6, 48'd0, 16'h00FF, 1'b0}, 48'd500}, 1'b0, '0},
      '{'{'{-32'sd1, -32'sd1, TIME_MAX, 16'hFFFF, 1'b1}, TIME_MAX - 48'd1}, 1'b1,
        '{-32'sd1, -32'sd1, TIME_MAX, 16'hFFFF, 1'b1}}
   };

   position_time_interpolator DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_fix_x     (req_fix_x),
      .req_fix_y     (req_fix_y),
      .req_fix_time  (req_fix_time),
      .req_fix_level (req_fix_level),
      .req_fix_empty (req_fix_empty),
      .req_now_time  (req_now_time),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_time  (rsp_out_time),
      .rsp_out_level (rsp_out_level),
      .rsp_out_empty (rsp_out_empty)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // (newer * e + older * (g - e)) / g, exact, truncated toward zero, then saturated.
   function automatic logic signed [pti_pkg::COORD_W-1:0] blend_coord(
      input logic signed [pti_pkg::COORD_W-1:0] newer_v,
      input logic signed [pti_pkg::COORD_W-1:0] older_v,
      input longint                             elapsed,
      input longint                             gap
   );
      logic signed [127:0] num;
      logic signed [127:0] quo;
      num = newer_v * elapsed + older_v * (gap - elapsed);
      quo = num / gap;
      if (quo > 128'sd2147483647) return pti_pkg::SAT_POS;
      if (quo < -128'sd2147483648) return pti_pkg::SAT_NEG;
      return quo[pti_pkg::COORD_W-1:0];
   endfunction

   function automatic fix_rec_type interpolate_fix(input fix_rec_type fix,
                                                   input logic [pti_pkg::TIME_W-1:0] now);
      fix_rec_type res;
      longint      elapsed;
      longint      gap;
      res = fix;
      if (now < fix.stamp) return res;
      if (prev_slot.level != fix.level || last_slot.level != fix.level) begin
         prev_slot = fix;
         last_slot = fix;
         return res;
      end
      if (prev_slot.empty || last_slot.empty || fix.empty) begin
         prev_slot = last_slot;
         last_slot = fix;
         return res;
      end
      if (fix.stamp > last_slot.stamp) begin
         prev_slot = last_slot;
         last_slot = fix;
      end
      if (last_slot.stamp == prev_slot.stamp) return last_slot;
      elapsed = longint'(now) - longint'(last_slot.stamp);
      gap = longint'(last_slot.stamp) - longint'(prev_slot.stamp);
      if (elapsed > gap) return res;
      res.x = blend_coord(last_slot.x, prev_slot.x, elapsed, gap);
      res.y = blend_coord(last_slot.y, prev_slot.y, elapsed, gap);
      res.stamp = now;
      res.level = last_slot.level;
      res.empty = last_slot.empty;
      return res;
   endfunction

   // Mostly no pause, sometimes a short pause, rarely a long one.
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic longint rand_upto(input longint hi);
      if (hi <= 0) return 0;
      if (hi < 64'h1_0000_0000) return $urandom_range(0, 32'(hi));
      return ({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF) % (hi + 1);
   endfunction

   function automatic longint rand_time();
      return longint'({$urandom, $urandom} & 64'h0000_FFFF_FFFF_FFFF);
   endfunction

   function automatic longint clamp_time(input longint v);
      if (v < 0) return 0;
      if (v > longint'(TIME_MAX)) return longint'(TIME_MAX);
      return v;
   endfunction

   function automatic logic [pti_pkg::LEVEL_W-1:0] pick_level();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'd1;
         2: return 16'd2;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic drive_request(input req_item_type it, input logic typed,
                                input fix_rec_type want);
      int          gap;
      fix_rec_type predicted;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_fix_x <= it.fix.x;
      req_fix_y <= it.fix.y;
      req_fix_time <= it.fix.stamp;
      req_fix_level <= it.fix.level;
      req_fix_empty <= it.fix.empty;
      req_now_time <= it.now;
      forever begin
         @(posedge clock);
         if (req_valid && !req_stall) break;
      end
      predicted = interpolate_fix(it.fix, it.now);
      expected_positions.push_back(typed ? want : predicted);
      requests_sent++;
   endtask

   task automatic send_fix(input logic signed [pti_pkg::COORD_W-1:0] x,
                           input logic signed [pti_pkg::COORD_W-1:0] y,
                           input longint stamp, input logic [pti_pkg::LEVEL_W-1:0] level,
                           input logic empty, input longint now);
      req_item_type it;
      it.fix.x = x;
      it.fix.y = y;
      it.fix.stamp = stamp[pti_pkg::TIME_W-1:0];
      it.fix.level = level;
      it.fix.empty = empty;
      it.now = now[pti_pkg::TIME_W-1:0];
      drive_request(it, 1'b0, '0);
   endtask

   task automatic send_noise();
      longint ft;
      longint now;
      ft = rand_time();
      if ($urandom_range(0, 1)) ft = ft >> $urandom_range(0, 40);
      now = $urandom_range(0, 1) ? rand_time() : clamp_time(ft + rand_upto(1000));
      send_fix($urandom, $urandom, ft, pick_level(), $urandom_range(0, 4) == 0, now);
   endtask

   // A run of fixes on one floor with queries between them, so that most
   // transfers reach the blend; a few empty, early or stray items are mixed in.
   task automatic run_track();
      longint                      t_old;
      longint                      t_new;
      longint                      gap;
      longint                      ft;
      longint                      dt;
      longint                      step_max;
      logic signed [31:0]          px;
      logic signed [31:0]          py;
      logic [pti_pkg::LEVEL_W-1:0] level;
      int                          span;
      int                          r;
      level = pick_level();
      calm = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: t_new = $urandom_range(0, 1 << 20);
         5, 6, 7: t_new = rand_time();
         default: t_new = longint'(TIME_MAX) - $urandom_range(0, 1 << 24);
      endcase
      case ($urandom_range(0, 3))
         0: step_max = 4;
         1: step_max = 100;
         2: step_max = 5000;
         default: step_max = 1000000;
      endcase
      span = 1 << $urandom_range(4, 29);
      px = $urandom;
      py = $urandom;
      t_old = t_new;
      send_fix(px, py, t_new, level, 1'b0, t_new);
      repeat ($urandom_range(4, 14)) begin
         r = $urandom_range(0, 99);
         dt = rand_upto(step_max - 1) + 1;
         gap = t_new - t_old;
         if (r < 30) begin
            t_old = t_new;
            t_new = clamp_time(t_new + dt);
            px = px + $urandom_range(0, 2 * span) - span;
            py = py + $urandom_range(0, 2 * span) - span;
            if ($urandom_range(0, 9) == 0) px = $urandom;
            if ($urandom_range(0, 9) == 0) py = $urandom;
            send_fix(px, py, t_new, level, 1'b0, clamp_time(t_new + rand_upto(dt + dt / 4)));
         end else if (r < 75) begin
            send_fix(px, py, t_new, level, 1'b0,
                     clamp_time(t_new + rand_upto(gap + gap / 4 + 1)));
         end else if (r < 85) begin
            ft = clamp_time(t_old - rand_upto(dt));
            send_fix($urandom, $urandom, ft, level, 1'b0,
                     clamp_time(ft + rand_upto(t_new - ft + gap)));
         end else if (r < 90) begin
            t_old = t_new;
            t_new = clamp_time(t_new + dt);
            send_fix($urandom, $urandom, t_new, level, 1'b1, clamp_time(t_new + rand_upto(dt)));
         end else if (r < 95) begin
            ft = clamp_time(t_new + dt);
            send_fix($urandom, $urandom, ft, level, 1'b0, clamp_time(ft - 1 - rand_upto(dt)));
         end else begin
            send_noise();
         end
      end
      calm = 1'b0;
   endtask

   task automatic wait_for_responses();
      @(negedge clock) req_valid <= 1'b0;
      while (expected_positions.size() != 0) @(posedge clock);
   endtask

   task automatic flag_field(input string name, input logic [63:0] want, input logic [63:0] got);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
   endtask

   always @(posedge clock) begin : check_responses
      fix_rec_type got;
      fix_rec_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_out_x, rsp_out_y, rsp_out_time, rsp_out_level, rsp_out_empty};
         if (expected_positions.size() == 0) begin
            mismatch_count++;
            $display("%0t: response transfer with no request outstanding, got %0h",
                     $time, got);
         end else begin
            want = expected_positions.pop_front();
            if (got.x !== want.x) flag_field("out_x", 64'(want.x), 64'(got.x));
            if (got.y !== want.y) flag_field("out_y", 64'(want.y), 64'(got.y));
            if (got.stamp !== want.stamp)
               flag_field("out_time", 64'(want.stamp), 64'(got.stamp));
            if (got.level !== want.level)
               flag_field("out_level", 64'(want.level), 64'(got.level));
            if (got.empty !== want.empty)
               flag_field("out_empty", 64'(want.empty), 64'(got.empty));
         end
      end
   end

   initial begin : stall_responses
      int stall_left;
      stall_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (calm) begin
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            stall_left = pick_gap();
            rsp_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      int next_drain;
      reset = 1'b1;
      req_valid = 1'b0;
      req_fix_x = '0;
      req_fix_y = '0;
      req_fix_time = '0;
      req_fix_level = '0;
      req_fix_empty = 1'b0;
      req_now_time = '0;
      calm = 1'b0;
      prev_slot = '{x: '0, y: '0, stamp: '0, level: '0, empty: 1'b1};
      last_slot = prev_slot;
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (directed_rows[i])
         drive_request(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

      next_drain = requests_sent + DRAIN_EVERY;
      while (requests_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) send_noise();
         else run_track();
         if (requests_sent >= next_drain) begin
            wait_for_responses();
            next_drain += DRAIN_EVERY;
         end
      end

      wait_for_responses();
      // Run on past the last expected response so that any extra one still shows up.
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && expected_positions.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
